// ===== rtl/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants
// Token format, operator codes and character codes for the expression
// evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package iee_pkg;

  localparam int OUT_WIDTH = 32;
  localparam int CHAR_WIDTH = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TK_OTHER = 2'd0,
    TK_DIGIT = 2'd1,
    TK_OP    = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  digit;
    op_t         op;
    logic        last;
  } token_t;

endpackage
`default_nettype wire

// ===== rtl/iee_in_if.sv =====
// ----------------------------------------------------------------------------
// iee_in_if: character input channel
// Carries one character and its end-of-expression mark per word.
// ----------------------------------------------------------------------------
`default_nettype none
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/iee_out_if.sv =====
// ----------------------------------------------------------------------------
// iee_out_if: result output channel
// Carries one evaluated expression and its status flags per word.
// ----------------------------------------------------------------------------
`default_nettype none
interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               div_by_zero;
  logic               malformed;

  modport source (output valid, output value, output div_by_zero, output malformed,
                  input ready);
  modport sink   (input valid, input value, input div_by_zero, input malformed,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/infix_integer_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator: two-stack infix evaluator
// Evaluates + - * / expressions over decimal integers, one character a word.
// ----------------------------------------------------------------------------
// A digit or ignored character is absorbed while the evaluator is idle; an
// operator goes to a decide step and, for each reduction that it triggers
// (at most two), through the shared arithmetic unit, which multiplies and
// divides one bit per cycle. The last character adds its reductions, a step
// to close a number that it ends as a digit, a step to decide and a step to
// load the result register. A classifier stage and a two-word token queue
// let characters be taken while the evaluator is busy; a result waiting at
// the output holds the evaluator only once the next expression is complete,
// and input then continues until the classifier and the queue are full.
`default_nettype none
module infix_integer_expression_evaluator #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire       clk,
  input  wire       rst,
  iee_in_if.sink    in_ch,
  iee_out_if.source out_ch
);
  import iee_pkg::*;

  token_t f_tok, q_tok;
  logic   f_valid, f_ready, q_valid, q_ready;

  iee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .tok       (f_tok),
    .tok_valid (f_valid),
    .tok_ready (f_ready)
  );

  iee_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_tok   (f_tok),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_tok   (q_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  iee_back #(.W(VALUE_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (q_tok),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

// ===== rtl/iee_front.sv =====
// ----------------------------------------------------------------------------
// iee_front: character classifier
// Accepts characters and registers them as digit, operator or other tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_front (
  input  wire                  clk,
  input  wire                  rst,
  iee_in_if.sink               in_ch,
  output iee_pkg::token_t      tok,
  output logic                 tok_valid,
  input  wire                  tok_ready
);
  import iee_pkg::*;

  token_t tok_class;

  always_comb begin
    tok_class.kind  = TK_OTHER;
    tok_class.digit = 4'(in_ch.char_code - CH_ZERO);
    tok_class.op    = OP_ADD;
    tok_class.last  = in_ch.last;
    if (in_ch.char_code >= CH_ZERO && in_ch.char_code <= CH_NINE) begin
      tok_class.kind = TK_DIGIT;
    end else begin
      priority case (in_ch.char_code)
        CH_PLUS:  begin tok_class.kind = TK_OP; tok_class.op = OP_ADD; end
        CH_MINUS: begin tok_class.kind = TK_OP; tok_class.op = OP_SUB; end
        CH_STAR:  begin tok_class.kind = TK_OP; tok_class.op = OP_MUL; end
        CH_SLASH: begin tok_class.kind = TK_OP; tok_class.op = OP_DIV; end
        default:  tok_class.kind = TK_OTHER;
      endcase
    end
  end

  assign in_ch.ready = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (in_ch.ready) begin
      tok_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      tok <= tok_class;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/iee_queue.sv =====
// ----------------------------------------------------------------------------
// iee_queue: token queue
// Two-entry queue that decouples the classifier from the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_queue (
  input  wire              clk,
  input  wire              rst,
  input  iee_pkg::token_t  wr_tok,
  input  wire              wr_valid,
  output logic             wr_ready,
  output iee_pkg::token_t  rd_tok,
  output logic             rd_valid,
  input  wire              rd_ready
);
  import iee_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  token_t             slots [QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [PtrW:0]      fill;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = (fill != (PtrW+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_tok   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (!do_wr && do_rd) fill <= fill - 1'b1;
    end
    if (do_wr) slots[wr_ptr] <= wr_tok;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= (PtrW+1)'(QUEUE_DEPTH))
    else $error("token queue fill out of range");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (fill == $past(fill) + 1'b1))
    else $error("token queue fill did not count a write");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == '0 || fill == (PtrW+1)'(QUEUE_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("token queue pointers disagree with fill");
`endif
endmodule
`default_nettype wire

// ===== rtl/iee_alu.sv =====
// ----------------------------------------------------------------------------
// iee_alu: iterative arithmetic unit
// Add and subtract finish in the cycle after start; multiply by shift-add and
// divide by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_alu #(
  parameter int W = 32
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  input  iee_pkg::op_t    op,
  input  wire  [W-1:0]    a,
  input  wire  [W-1:0]    b,
  output logic            done,
  output logic [W-1:0]    res,
  output logic            dz
);
  import iee_pkg::*;

  localparam int CW = $clog2(W+1);

  logic          busy;
  op_t           opr;
  logic [CW-1:0] cnt;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [W-1:0]  acc;
  logic          neg;
  logic [W-1:0]  acc_step;
  logic [W:0]    rem_sh;
  logic          qbit;
  logic [W-1:0]  rem_step;
  logic [W-1:0]  q_step;

  always_comb begin
    acc_step = y[0] ? acc + x : acc;
    rem_sh   = {acc, x[W-1]};
    qbit     = (rem_sh >= {1'b0, y});
    rem_step = qbit ? W'(rem_sh - {1'b0, y}) : rem_sh[W-1:0];
    q_step   = {x[W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        opr <= op;
        dz  <= 1'b0;
        unique case (op)
          OP_ADD: begin res <= a + b; done <= 1'b1; end
          OP_SUB: begin res <= a - b; done <= 1'b1; end
          OP_MUL: begin
            x <= a; y <= b; acc <= '0; cnt <= CW'(W); busy <= 1'b1;
          end
          OP_DIV: begin
            if (b == '0) begin
              res <= '0; dz <= 1'b1; done <= 1'b1;
            end else begin
              // Work on magnitudes; the quotient forms in x, the remainder in acc.
              x   <= a[W-1] ? W'(-a) : a;
              y   <= b[W-1] ? W'(-b) : b;
              acc <= '0;
              neg <= a[W-1] ^ b[W-1];
              cnt <= CW'(W);
              busy <= 1'b1;
            end
          end
          default: done <= 1'b1;
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (opr == OP_MUL) begin
          acc <= acc_step;
          x   <= x << 1;
          y   <= y >> 1;
          if (cnt == CW'(1)) begin
            res <= acc_step; done <= 1'b1; busy <= 1'b0;
          end
        end else begin
          acc <= rem_step;
          x   <= q_step;
          if (cnt == CW'(1)) begin
            res <= neg ? W'(-q_step) : q_step; done <= 1'b1; busy <= 1'b0;
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("operation started while the unit was busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("completion held for more than one cycle");
  a_dz_div: assert property (@(posedge clk) disable iff (rst)
    (done && dz) |-> (opr == OP_DIV && res == '0))
    else $error("zero-divisor flag without a zero quotient");
`endif
endmodule
`default_nettype wire

// ===== rtl/iee_back.sv =====
// ----------------------------------------------------------------------------
// iee_back: expression evaluator
// Runs the number and operator stacks, sequences reductions through the
// arithmetic unit and delivers the result word.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_back #(
  parameter int W = 32
) (
  input  wire              clk,
  input  wire              rst,
  input  iee_pkg::token_t  tok,
  input  wire              tok_valid,
  output logic             tok_ready,
  iee_out_if.source        out_ch
);
  import iee_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STEP  = 4'b0010,
    S_ALU   = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  state_t       state;
  logic [W-1:0] n0, n1, n2;
  logic [1:0]   num_count;
  op_t          op0, op1;
  logic [1:0]   op_count;
  logic [W-1:0] acc;
  logic         in_number;
  logic         err_div, err_bad;
  op_t          pend_op;
  logic         pend_valid, pend_last;

  logic [W-1:0] acc_base, acc_mac;
  logic         push_en;
  logic         reduce_go;
  logic         alu_start, alu_done, alu_dz;
  logic [W-1:0] alu_res;
  logic [W-1:0] final_val;
  logic         out_free;

  assign tok_ready = (state == S_IDLE);
  assign out_free  = !out_ch.valid || out_ch.ready;

  always_comb begin
    acc_base = in_number ? acc : '0;
    acc_mac  = (acc_base << 3) + (acc_base << 1) + W'(tok.digit);
    push_en  = 1'b0;
    if (state == S_IDLE && tok_valid && tok.kind != TK_DIGIT && in_number) push_en = 1'b1;
    if (state == S_STEP && !pend_valid && pend_last && in_number) push_en = 1'b1;
    // Reduce while the top operator binds at least as tightly as the new one, or at the end.
    reduce_go = pend_valid ? (op_count != 2'd0 && op0[1] >= pend_op[1])
                           : (pend_last && !in_number && op_count != 2'd0);
    alu_start = (state == S_STEP) && reduce_go && (num_count >= 2'd2);
    final_val = (num_count == 2'd0) ? '0 : n0;
  end

  iee_alu #(.W(W)) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (op0),
    .a     (n1),
    .b     (n0),
    .done  (alu_done),
    .res   (alu_res),
    .dz    (alu_dz)
  );

  generate
    if (W >= OUT_WIDTH) begin : g_trunc
      always_ff @(posedge clk) begin
        if (state == S_FINAL && out_free) out_ch.value <= final_val[OUT_WIDTH-1:0];
      end
    end else begin : g_sext
      always_ff @(posedge clk) begin
        if (state == S_FINAL && out_free) begin
          out_ch.value <= {{(OUT_WIDTH-W){final_val[W-1]}}, final_val};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      num_count    <= '0;
      op_count     <= '0;
      in_number    <= 1'b0;
      acc          <= '0;
      err_div      <= 1'b0;
      err_bad      <= 1'b0;
      pend_valid   <= 1'b0;
      pend_last    <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // A new result may be loaded in the same cycle the old one is taken.
      out_ch.valid <= (state == S_FINAL && out_free) || (out_ch.valid && !out_ch.ready);
      unique case (state)
        S_IDLE: begin
          if (tok_valid) begin
            pend_op    <= tok.op;
            pend_valid <= (tok.kind == TK_OP);
            pend_last  <= tok.last;
            if (tok.kind == TK_DIGIT) begin
              acc       <= acc_mac;
              in_number <= 1'b1;
            end
            if (tok.kind == TK_OP || tok.last) state <= S_STEP;
          end
        end
        S_STEP: begin
          if (reduce_go) begin
            op_count <= op_count - 1'b1;
            op0      <= op1;
            if (num_count < 2'd2) err_bad <= 1'b1;
            else state <= S_ALU;
          end else if (pend_valid) begin
            pend_valid <= 1'b0;
            if (op_count == 2'd2) begin
              err_bad <= 1'b1;
            end else begin
              op1      <= op0;
              op0      <= pend_op;
              op_count <= op_count + 1'b1;
            end
            if (!pend_last) state <= S_IDLE;
          end else if (!in_number) begin
            state <= pend_last ? S_FINAL : S_IDLE;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            n0        <= alu_res;
            n1        <= n2;
            num_count <= num_count - 1'b1;
            if (alu_dz) err_div <= 1'b1;
            state <= S_STEP;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_ch.div_by_zero <= err_div;
            out_ch.malformed   <= err_bad || (num_count != 2'd1);
            num_count  <= '0;
            op_count   <= '0;
            err_div    <= 1'b0;
            err_bad    <= 1'b0;
            pend_last  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (push_en) begin
        in_number <= 1'b0;
        acc       <= '0;
        if (num_count == 2'd3) begin
          err_bad <= 1'b1;
        end else begin
          n2        <= n1;
          n1        <= n0;
          n0        <= acc;
          num_count <= num_count + 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_op_depth: assert property (@(posedge clk) disable iff (rst)
    op_count != 2'd3)
    else $error("operator stack overflow");
  a_alu_state: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == S_ALU))
    else $error("arithmetic result arrived outside the wait state");
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && out_free) |=>
      (num_count == 2'd0 && op_count == 2'd0 && out_ch.valid && state == S_IDLE))
    else $error("state not cleared after delivering a result");
  a_start_reduce: assert property (@(posedge clk) disable iff (rst)
    alu_start |=> (state == S_ALU))
    else $error("reduction started without waiting for the unit");
`endif
endmodule
`default_nettype wire
